[design/arpe_pkg.sv]
// arpe_pkg: shared types and constants for the ARP/ICMP echo responder.
// No dependencies; arpe_ctrl, arpe_dp and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package arpe_pkg;

    // Header buffer geometry
    localparam int unsigned HDR_LEN = 42;
    localparam int unsigned IDX_W   = 6;

    // Checksum sequencing: one header word per step, steps 0..CSUM_LAST
    localparam logic [2:0] CSUM_LAST = 3'd6;

    // Configuration register indexes
    localparam logic [0:0] CFG_LOCAL_IP  = 1'b0;
    localparam logic [0:0] CFG_LOCAL_MAC = 1'b1;
    localparam int unsigned CFG_DATA_W   = 48;

    localparam logic [47:0] LOCAL_MAC_RESET = 48'h6161_6161_6161;

    // Frame status codes
    localparam logic [2:0] ST_ARP_REPLY    = 3'd0;
    localparam logic [2:0] ST_ICMP_REPLY   = 3'd1;
    localparam logic [2:0] ST_OTHER        = 3'd2;
    localparam logic [2:0] ST_ARP_NOT_OURS = 3'd3;
    localparam logic [2:0] ST_SHORT        = 3'd4;

    // Protocol constants
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] IP_VER_IHL    = 16'h4500;
    localparam logic [7:0]  IP_TTL        = 8'h40;
    localparam logic [7:0]  IP_PROTO_ICMP = 8'h01;
    localparam logic [15:0] ETH_HDR_LEN   = 16'd14;

    // Controller -> datapath commands
    typedef struct packed {
        logic       store;       // write received byte into header buffer
        logic       latch_full;  // 42nd byte taken
        logic       latch_short; // frame ended before 42 bytes
        logic       calc;        // checksum / classify step
        logic [2:0] calc_step;
        logic       emit;        // load next header byte into output register
        logic       pass;        // load received payload byte into output register
    } ctrl_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic out_free;   // output register can take a byte this cycle
        logic hdr_full;   // current byte completes the header
        logic emit_done;  // header byte being emitted is the final one
        logic frame_ends; // frame is over once the header burst is out
    } dp_status_t;

endpackage

`default_nettype wire

[design/arpe_rx_if.sv]
// arpe_rx_if: received byte channel (valid/ready plus frame byte payload).
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface arpe_rx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [15:0] frame_length;

    modport source (output valid, output frame_byte, output last_byte,
                    output frame_length, input ready);
    modport sink   (input valid, input frame_byte, input last_byte,
                    input frame_length, output ready);
endinterface

`default_nettype wire

[design/arpe_tx_if.sv]
// arpe_tx_if: reply byte channel (valid/ready plus reply byte and status).
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface arpe_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] frame_status;

    modport source (output valid, output out_byte, output out_last,
                    output frame_status, input ready);
    modport sink   (input valid, input out_byte, input out_last,
                    input frame_status, output ready);
endinterface

`default_nettype wire

[design/arpe_ctrl.sv]
// arpe_ctrl: frame sequencing state machine (collect, checksum, emit, pass).
// Depends on arpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arpe_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_last,
    output logic                       in_ready,
    input  wire arpe_pkg::dp_status_t  stat,
    output arpe_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [3:0] {
        S_COLLECT = 4'b0001,
        S_CALC    = 4'b0010,
        S_EMIT    = 4'b0100,
        S_PASS    = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic [2:0]  step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_COLLECT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (stat.hdr_full)
                    begin
                        cmd.latch_full = 1'b1;
                        state_next     = S_CALC;
                        step_next      = '0;
                    end
                    else if (in_last)
                    begin
                        cmd.latch_short = 1'b1;
                        state_next      = S_CALC;
                        step_next       = '0;
                    end
                end
            end
            S_CALC:
            begin
                cmd.calc      = 1'b1;
                cmd.calc_step = step_reg;
                if (step_reg == arpe_pkg::CSUM_LAST)
                    state_next = S_EMIT;
                else
                    step_next = step_reg + 3'd1;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.emit_done)
                        state_next = stat.frame_ends ? S_COLLECT : S_PASS;
                end
            end
            S_PASS:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    cmd.pass = 1'b1;
                    if (in_last)
                        state_next = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // Last header byte of a frame that already ended returns to collection
    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.emit_done && stat.frame_ends) |=> (state_reg == S_COLLECT))
        else $error("frame did not close after final header byte");

    // Checksum pass always starts at step zero after a header is latched
    a_calc_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.latch_full || cmd.latch_short) |=> (state_reg == S_CALC && step_reg == 3'd0))
        else $error("checksum pass did not start at step zero");

endmodule

`default_nettype wire

[design/arpe_dp.sv]
// arpe_dp: header buffer, field captures, checksums, byte rewrite and output register.
// Depends on arpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arpe_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire arpe_pkg::ctrl_cmd_t             cmd,
    output arpe_pkg::dp_status_t                 stat,
    input  wire logic [7:0]                      in_byte,
    input  wire logic                            in_last,
    input  wire logic [15:0]                     in_length,
    input  wire logic                            cfg_we,
    input  wire logic [0:0]                      cfg_index,
    input  wire logic [arpe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [7:0]                           out_byte,
    output logic                                 out_last,
    output logic [2:0]                           out_status
);

    localparam int unsigned IW = arpe_pkg::IDX_W;

    // ones' complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        return mac[{3'd5 - k, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
        return ip[{2'd3 - k, 3'b000} +: 8];
    endfunction

    // Configuration
    logic [31:0] local_ip_reg;
    logic [47:0] local_mac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg  <= '0;
            local_mac_reg <= arpe_pkg::LOCAL_MAC_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == arpe_pkg::CFG_LOCAL_IP)
                local_ip_reg <= cfg_data[31:0];
            else
                local_mac_reg <= cfg_data[47:0];
        end
    end

    // Header buffer: one write port (receive), one registered read port (emit)
    logic [7:0]    hdr_mem [arpe_pkg::HDR_LEN];
    logic [7:0]    rd_data_reg;
    logic [IW-1:0] rd_addr;

    // Field captures: bytes 6..13, 22..31, 34..41
    logic [7:0] cap_a_reg [8];
    logic [7:0] cap_b_reg [10];
    logic [7:0] cap_c_reg [8];

    logic [IW-1:0] pos_reg, idx_reg, cnt_reg;
    logic [2:0]    class_reg;
    logic          hdr_last_reg;
    logic [15:0]   tl_reg, acc_reg, icmp_ck_reg;

    logic [IW-1:0] cnt_m1;
    assign cnt_m1 = cnt_reg - IW'(1);

    assign stat.hdr_full   = (pos_reg == IW'(arpe_pkg::HDR_LEN - 1));
    assign stat.emit_done  = (idx_reg == cnt_m1);
    assign stat.frame_ends = hdr_last_reg;
    assign stat.out_free   = !out_valid || out_ready;

    assign rd_addr = (cmd.emit && !stat.emit_done) ? (idx_reg + IW'(1)) : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            hdr_mem[pos_reg] <= in_byte;
        rd_data_reg <= hdr_mem[rd_addr];
    end

    logic [IW-1:0] off_a, off_b, off_c;
    assign off_a = pos_reg - IW'(6);
    assign off_b = pos_reg - IW'(22);
    assign off_c = pos_reg - IW'(34);

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            if (pos_reg >= IW'(6) && pos_reg <= IW'(13))
                cap_a_reg[off_a[2:0]] <= in_byte;
            if (pos_reg >= IW'(22) && pos_reg <= IW'(31))
                cap_b_reg[off_b[3:0]] <= in_byte;
            if (pos_reg >= IW'(34) && pos_reg <= IW'(41))
                cap_c_reg[off_c[2:0]] <= in_byte;
        end
    end

    // Captured fields
    logic [15:0] eth_type, icmp_hc, icmp_m, word;
    logic [31:0] arp_tpa;
    logic [2:0]  class_calc;

    assign eth_type = {cap_a_reg[6], cap_a_reg[7]};
    assign icmp_m   = {cap_c_reg[0], cap_c_reg[1]};
    assign icmp_hc  = {cap_c_reg[2], cap_c_reg[3]};
    assign arp_tpa  = {cap_c_reg[4], cap_c_reg[5], cap_c_reg[6], cap_c_reg[7]};

    always_comb
    begin
        if (eth_type == arpe_pkg::ETH_TYPE_ARP)
            class_calc = (arp_tpa == local_ip_reg) ? arpe_pkg::ST_ARP_REPLY
                                                   : arpe_pkg::ST_ARP_NOT_OURS;
        else if (eth_type == arpe_pkg::ETH_TYPE_IPV4 && cap_b_reg[1] == arpe_pkg::IP_PROTO_ICMP)
            class_calc = arpe_pkg::ST_ICMP_REPLY;
        else
            class_calc = arpe_pkg::ST_OTHER;
    end

    // IP header words that are nonzero, one per checksum step
    always_comb
    begin
        case (cmd.calc_step)
            3'd0:    word = arpe_pkg::IP_VER_IHL;
            3'd1:    word = tl_reg;
            3'd2:    word = {arpe_pkg::IP_TTL, arpe_pkg::IP_PROTO_ICMP};
            3'd3:    word = local_ip_reg[31:16];
            3'd4:    word = local_ip_reg[15:0];
            3'd5:    word = {cap_b_reg[4], cap_b_reg[5]};
            3'd6:    word = {cap_b_reg[6], cap_b_reg[7]};
            default: word = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            class_reg    <= arpe_pkg::ST_ARP_REPLY;
            hdr_last_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store)
                pos_reg <= pos_reg + IW'(1);
            if (cmd.latch_full)
            begin
                cnt_reg      <= IW'(arpe_pkg::HDR_LEN);
                idx_reg      <= '0;
                hdr_last_reg <= in_last;
                class_reg    <= arpe_pkg::ST_OTHER;
            end
            if (cmd.latch_short)
            begin
                cnt_reg      <= pos_reg + IW'(1);
                idx_reg      <= '0;
                hdr_last_reg <= 1'b1;
                class_reg    <= arpe_pkg::ST_SHORT;
            end
            if (cmd.calc && cmd.calc_step == 3'd0 && class_reg != arpe_pkg::ST_SHORT)
                class_reg <= class_calc;
            if (cmd.emit)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (stat.emit_done)
                    pos_reg <= '0;
            end
        end
    end

    // Checksums; RFC 1624 update with the new type/code word equal to zero
    always_ff @(posedge clk)
    begin
        if (cmd.latch_full)
            tl_reg <= in_length - arpe_pkg::ETH_HDR_LEN;
        if (cmd.calc)
        begin
            if (cmd.calc_step == 3'd0)
            begin
                acc_reg     <= word;
                icmp_ck_reg <= ~oc_add(~icmp_hc, ~icmp_m);
            end
            else
                acc_reg <= oc_add(acc_reg, word);
        end
    end

    // Rewritten header byte at idx_reg
    logic [IW-1:0] off_mac, off_sha, off_spa, off_lip, off_cap;
    logic [7:0]    eb;
    logic [15:0]   ip_ck;

    assign off_mac = idx_reg - IW'(6);
    assign off_sha = idx_reg - IW'(22);
    assign off_spa = idx_reg - IW'(28);
    assign off_lip = idx_reg - IW'(26);
    assign off_cap = (class_reg == arpe_pkg::ST_ICMP_REPLY) ? (idx_reg - IW'(26))
                                                           : (idx_reg - IW'(32));
    assign ip_ck   = ~acc_reg;

    always_comb
    begin
        eb = rd_data_reg;
        if (class_reg != arpe_pkg::ST_SHORT)
        begin
            if (idx_reg < IW'(6))
                eb = cap_a_reg[idx_reg[2:0]];
            else if (idx_reg < IW'(12))
                eb = mac_byte(local_mac_reg, off_mac[2:0]);
            else if (class_reg == arpe_pkg::ST_ARP_REPLY)
            begin
                if (idx_reg >= IW'(32))
                    eb = cap_b_reg[off_cap[3:0]];
                else if (idx_reg >= IW'(28))
                    eb = ip_byte(local_ip_reg, off_spa[1:0]);
                else if (idx_reg >= IW'(22))
                    eb = mac_byte(local_mac_reg, off_sha[2:0]);
                else
                begin
                    case (idx_reg)
                        IW'(15): eb = 8'h01;
                        IW'(16): eb = 8'h08;
                        IW'(18): eb = 8'h06;
                        IW'(19): eb = 8'h04;
                        IW'(21): eb = 8'h02;
                        IW'(14), IW'(17), IW'(20): eb = 8'h00;
                        default: eb = rd_data_reg;
                    endcase
                end
            end
            else if (class_reg == arpe_pkg::ST_ICMP_REPLY)
            begin
                if (idx_reg >= IW'(30) && idx_reg <= IW'(33))
                    eb = cap_b_reg[off_cap[3:0]];
                else if (idx_reg >= IW'(26) && idx_reg <= IW'(29))
                    eb = ip_byte(local_ip_reg, off_lip[1:0]);
                else
                begin
                    case (idx_reg)
                        IW'(14): eb = arpe_pkg::IP_VER_IHL[15:8];
                        IW'(15): eb = arpe_pkg::IP_VER_IHL[7:0];
                        IW'(16): eb = tl_reg[15:8];
                        IW'(17): eb = tl_reg[7:0];
                        IW'(18), IW'(19), IW'(20), IW'(21),
                        IW'(34), IW'(35): eb = 8'h00;
                        IW'(22): eb = arpe_pkg::IP_TTL;
                        IW'(23): eb = arpe_pkg::IP_PROTO_ICMP;
                        IW'(24): eb = ip_ck[15:8];
                        IW'(25): eb = ip_ck[7:0];
                        IW'(36): eb = icmp_ck_reg[15:8];
                        IW'(37): eb = icmp_ck_reg[7:0];
                        default: eb = rd_data_reg;
                    endcase
                end
            end
        end
    end

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [2:0] out_status_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.emit || cmd.pass)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg   <= eb;
            out_last_reg   <= stat.emit_done && hdr_last_reg;
            out_status_reg <= class_reg;
        end
        else if (cmd.pass)
        begin
            out_byte_reg   <= in_byte;
            out_last_reg   <= in_last;
            out_status_reg <= class_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (idx_reg < cnt_reg))
        else $error("header emit index past byte count");

    a_store_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (pos_reg < IW'(arpe_pkg::HDR_LEN)))
        else $error("header store past buffer end");

    a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.emit_done && class_reg == arpe_pkg::ST_SHORT) |=> out_last_reg)
        else $error("short frame burst without final marker");

endmodule

`default_nettype wire

[design/arp_icmp_echo_responder.sv]
// arp_icmp_echo_responder: top level of the ARP / ICMP echo reply responder.
// Depends on arpe_pkg, arpe_rx_if, arpe_tx_if, arpe_ctrl and arpe_dp.
`timescale 1ns / 1ps
`default_nettype none

// Takes a received Ethernet frame one byte per request on rx and returns the
// reply frame one byte per request on tx. The first 42 bytes are collected
// at one per cycle into a header buffer; then a checksum pass computes the IP
// header checksum (one 16-bit word per cycle through a ones' complement
// adder), classifies the frame and updates the ICMP checksum incrementally.
// The 42 rewritten header bytes then leave at one per cycle while tx is ready,
// from the buffer's registered read port while rx is held off, and every
// later payload byte passes through at one per cycle while rx and tx allow.
// A frame shorter than 42 bytes is echoed unchanged with status 4. Every
// reply to a frame of 42 bytes or more swaps the MAC addresses (source
// becomes local_mac); an ARP frame whose target IP equals local_ip becomes
// an ARP reply (status 0) and other ARP frames get status 3; IPv4 protocol 1
// gets a rebuilt IP header and an echo reply header (status 1); anything else
// keeps its body (status 2). frame_length is sampled with the 42nd byte.
// Configuration (index 0 local_ip, index 1 local_mac) is written through
// cfg_we / cfg_index / cfg_data, by the user only while the block is idle;
// the block does not enforce this. No clearing pass is needed after reset.
module arp_icmp_echo_responder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    arpe_rx_if.sink                              rx,
    arpe_tx_if.source                            tx,
    input  wire logic                            cfg_we,
    input  wire logic [0:0]                      cfg_index,
    input  wire logic [arpe_pkg::CFG_DATA_W-1:0] cfg_data
);

    arpe_pkg::ctrl_cmd_t  cmd;
    arpe_pkg::dp_status_t stat;
    logic                 in_ready;

    // Sequencer: collect, checksum, header burst, payload pass-through
    arpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_last  (rx.last_byte),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign rx.ready = in_ready;

    // Header buffer, field captures, rewrite mux and output register
    arpe_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_byte    (rx.frame_byte),
        .in_last    (rx.last_byte),
        .in_length  (rx.frame_length),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_ready  (tx.ready),
        .out_valid  (tx.valid),
        .out_byte   (tx.out_byte),
        .out_last   (tx.out_last),
        .out_status (tx.frame_status)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
// tb: self-checking testbench for arp_icmp_echo_responder (ARP / ICMP echo replies).
// Needs arpe_pkg, arpe_rx_if, arpe_tx_if and the responder RTL; nothing else.
`timescale 1ns / 1ps

// Frames go in one byte per request on the rx channel. A scoreboard in this
// module keeps its own copy of the header buffer and the addresses, rewrites
// each frame the way the responder should, and queues every expected reply
// byte. Each reply byte that leaves on tx is compared field by field with the
// oldest queued one. A fixed plan of frames runs first. Its statuses are typed
// in where they are obvious: short frame, our ARP, someone else's ARP, echo
// request, plain IPv4, other ethertype. Random frames follow in three rounds
// of back-pressure.
module tb;
    import arpe_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int SETTLE = 16;        // cycles after the last reply before a register write
    localparam int STALL_LIMIT = 2000; // cycles with no request moving on either side
    localparam int ROUND_BYTES = 80;   // random bytes per back-pressure round
    localparam int BUF_LEN = 128;

    // Header field values the reply must carry
    localparam logic [15:0] ARP_HTYPE_ETH = 16'h0001;
    localparam logic [7:0] ARP_HLEN = 8'd6;
    localparam logic [7:0] ARP_PLEN = 8'd4;
    localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
    localparam logic [15:0] ICMP_ECHO_REPLY = 16'h0000; // type and code
    // Ethertypes that must not be mistaken for ARP or IPv4
    localparam logic [15:0] ETH_TYPE_ARP_SWAPPED = 16'h0608;
    localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86dd;

    typedef enum logic [2:0] {
        FR_RAW,        // random bytes, ethertype included
        FR_ARP_OURS,   // ARP aimed at our address
        FR_ARP_OTHER,  // ARP aimed elsewhere
        FR_ICMP_ECHO,  // IPv4, protocol 1
        FR_IPV4_OTHER, // IPv4, any other protocol
        FR_ETH_OTHER   // neither ARP nor IPv4
    } frame_kind_e;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_e;

    typedef struct packed {
        frame_kind_e kind;
        fill_e fill;
        logic [7:0] len;
        logic [15:0] flen;
        logic set_cfg;   // write both address registers before the frame
        logic [31:0] ip;
        logic [47:0] mac;
        logic typed;     // status of the reply is given in the row
        logic [2:0] st;
    } frame_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic last;
        logic [2:0] status;
    } reply_t;

    // Directed plan. Columns: kind, fill, length, frame_length, write config,
    // local_ip, local_mac, status typed, status.
    localparam int N_PLAN = 12;
    localparam frame_row_t PLAN [N_PLAN] = '{
        // single byte right after reset
        '{FR_RAW, FILL_RANDOM, 8'd1, 16'd1, 1'b0, 32'h0, 48'h0, 1'b1, ST_SHORT},
        // one byte short of a header, echo request look
        '{FR_ICMP_ECHO, FILL_ONES, 8'd41, 16'd41, 1'b0, 32'h0, 48'h0, 1'b1, ST_SHORT},
        // exactly a header, ARP for 0.0.0.0 under reset addresses
        '{FR_ARP_OURS, FILL_ZERO, 8'd42, 16'd42, 1'b0, 32'h0, 48'h0, 1'b1, ST_ARP_REPLY},
        '{FR_ARP_OTHER, FILL_RANDOM, 8'd60, 16'd60, 1'b0, 32'h0, 48'h0, 1'b1,
          ST_ARP_NOT_OURS},
        // frame_length below 14: total length wraps
        '{FR_ICMP_ECHO, FILL_RANDOM, 8'd74, 16'd0, 1'b0, 32'h0, 48'h0, 1'b1, ST_ICMP_REPLY},
        '{FR_ARP_OURS, FILL_ONES, 8'd44, 16'hffff, 1'b1, 32'hffff_ffff,
          48'hffff_ffff_ffff, 1'b1, ST_ARP_REPLY},
        '{FR_ICMP_ECHO, FILL_ONES, 8'd43, 16'hffff, 1'b0, 32'h0, 48'h0, 1'b1, ST_ICMP_REPLY},
        '{FR_IPV4_OTHER, FILL_RANDOM, 8'd50, 16'd50, 1'b0, 32'h0, 48'h0, 1'b1, ST_OTHER},
        '{FR_ETH_OTHER, FILL_ZERO, 8'd45, 16'd45, 1'b1, 32'h0, 48'h0, 1'b1, ST_OTHER},
        // all-zero echo request, total length zero
        '{FR_ICMP_ECHO, FILL_ZERO, 8'd42, 16'd14, 1'b0, 32'h0, 48'h0, 1'b1, ST_ICMP_REPLY},
        '{FR_ARP_OURS, FILL_RANDOM, 8'd48, 16'd13, 1'b0, 32'h0, 48'h0, 1'b1, ST_ARP_REPLY},
        '{FR_RAW, FILL_RANDOM, 8'd40, 16'd40, 1'b1, 32'hc0a8_0001, 48'h0200_5e10_2a7f,
          1'b1, ST_SHORT}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    arpe_rx_if rx_ch ();
    arpe_tx_if tx_ch ();

    arp_icmp_echo_responder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .tx        (tx_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Scoreboard state: header bytes seen so far, address registers, and
    // the status of the frame in flight (payload bytes inherit it).
    logic [7:0] rx_header [HDR_LEN];
    logic [7:0] tx_header [HDR_LEN];
    int unsigned header_fill = 0;
    logic [2:0] frame_class = ST_ARP_REPLY;
    logic [31:0] own_ip = '0;
    logic [47:0] own_mac = LOCAL_MAC_RESET;
    reply_t pending_replies [$];

    // Plan rows force the expected status of their frame
    logic row_status_valid = 1'b0;
    logic [2:0] row_status = ST_ARP_REPLY;

    int send_idle;
    int recv_idle;
    int mismatches = 0;
    int quiet_cycles = 0;
    logic [7:0] frame_buf [BUF_LEN];

    function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = a + b;
        return s[15:0] + s[16];
    endfunction

    function automatic void queue_reply(logic [7:0] data, logic last, logic [2:0] st);
        reply_t r;
        r.data = data;
        r.last = last;
        r.status = row_status_valid ? row_status : st;
        pending_replies.push_back(r);
    endfunction

    // Takes one accepted request and queues the reply bytes it releases.
    task automatic predict_reply(input logic [7:0] b, input logic l, input logic [15:0] fl);
        int i;
        logic [15:0] eth_type;
        logic [15:0] tl;
        logic [15:0] sum;
        logic [15:0] hc;
        logic [15:0] m;
        if (header_fill >= HDR_LEN)
        begin
            // payload passes straight through
            queue_reply(b, l, frame_class);
            if (l)
                header_fill = 0;
            return;
        end
        rx_header[header_fill] = b;
        header_fill++;
        if (header_fill < HDR_LEN)
        begin
            if (l)
            begin
                // short frame: echo what came in, untouched
                frame_class = ST_SHORT;
                for (i = 0; i < header_fill; i++)
                    queue_reply(rx_header[i], i == header_fill - 1, ST_SHORT);
                header_fill = 0;
            end
            return;
        end

        // Full header: MAC swap always, then the protocol rewrite
        for (i = 0; i < HDR_LEN; i++)
            tx_header[i] = rx_header[i];
        for (i = 0; i < 6; i++)
        begin
            tx_header[i] = rx_header[6 + i];
            tx_header[6 + i] = own_mac[47 - 8 * i -: 8];
        end
        eth_type = {rx_header[12], rx_header[13]};
        frame_class = ST_OTHER;
        if (eth_type == ETH_TYPE_ARP)
        begin
            frame_class = ST_ARP_NOT_OURS;
            if ({rx_header[38], rx_header[39], rx_header[40], rx_header[41]} == own_ip)
            begin
                // opcode of the request is not looked at
                frame_class = ST_ARP_REPLY;
                {tx_header[14], tx_header[15]} = ARP_HTYPE_ETH;
                {tx_header[16], tx_header[17]} = ETH_TYPE_IPV4;
                tx_header[18] = ARP_HLEN;
                tx_header[19] = ARP_PLEN;
                {tx_header[20], tx_header[21]} = ARP_OP_REPLY;
                for (i = 0; i < 6; i++)
                begin
                    tx_header[32 + i] = rx_header[22 + i];
                    tx_header[22 + i] = own_mac[47 - 8 * i -: 8];
                end
                for (i = 0; i < 4; i++)
                begin
                    tx_header[38 + i] = rx_header[28 + i];
                    tx_header[28 + i] = own_ip[31 - 8 * i -: 8];
                end
            end
        end
        else if (eth_type == ETH_TYPE_IPV4 && rx_header[23] == IP_PROTO_ICMP)
        begin
            frame_class = ST_ICMP_REPLY;
            tl = fl - ETH_HDR_LEN;
            {tx_header[14], tx_header[15]} = IP_VER_IHL;
            {tx_header[16], tx_header[17]} = tl;
            for (i = 18; i < 22; i++)
                tx_header[i] = 8'h00;
            tx_header[22] = IP_TTL;
            tx_header[23] = IP_PROTO_ICMP;
            tx_header[24] = 8'h00;
            tx_header[25] = 8'h00;
            for (i = 0; i < 4; i++)
            begin
                tx_header[30 + i] = rx_header[26 + i];
                tx_header[26 + i] = own_ip[31 - 8 * i -: 8];
            end
            sum = '0;
            for (i = 14; i < 34; i += 2)
                sum = ones_add(sum, {tx_header[i], tx_header[i + 1]});
            {tx_header[24], tx_header[25]} = ~sum;
            // ICMP checksum: incremental update for type/code going to zero
            hc = {rx_header[36], rx_header[37]};
            m = {rx_header[34], rx_header[35]};
            {tx_header[34], tx_header[35]} = ICMP_ECHO_REPLY;
            {tx_header[36], tx_header[37]} = ~ones_add(~hc, ~m);
        end
        for (i = 0; i < HDR_LEN; i++)
            queue_reply(tx_header[i], (i == HDR_LEN - 1) ? l : 1'b0, frame_class);
        if (l)
            header_fill = 0;
    endtask

    // Scoreboard: config writes, rx requests, tx replies, all sampled here
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_LOCAL_IP)
                    own_ip = cfg_data[31:0];
                else
                    own_mac = cfg_data;
            end
            if (rx_ch.valid && rx_ch.ready)
                predict_reply(rx_ch.frame_byte, rx_ch.last_byte, rx_ch.frame_length);
            if (tx_ch.valid && tx_ch.ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("reply byte %h with nothing pending", tx_ch.out_byte);
                    mismatches++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (tx_ch.out_byte !== want.data)
                    begin
                        $error("out_byte: expected %h, got %h", want.data, tx_ch.out_byte);
                        mismatches++;
                    end
                    if (tx_ch.out_last !== want.last)
                    begin
                        $error("out_last: expected %b, got %b", want.last, tx_ch.out_last);
                        mismatches++;
                    end
                    if (tx_ch.frame_status !== want.status)
                    begin
                        $error("frame_status: expected %0d, got %0d", want.status,
                               tx_ch.frame_status);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: the run is dead if no request moves for too long
    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Reply side back-pressure, one decision per cycle
    always @(negedge clk)
        tx_ch.ready <= ($urandom_range(99) >= recv_idle);

    // Hold the sender until every queued reply is out, plus a margin for
    // the block to go quiet.
    task automatic drain_replies();
        rx_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Writes both address registers on back-to-back cycles; block is idle
    task automatic load_addresses(input logic [31:0] ip, input logic [47:0] mac);
        cfg_we <= 1'b1;
        cfg_index <= CFG_LOCAL_IP;
        cfg_data <= {16'h0000, ip};
        @(negedge clk);
        cfg_index <= CFG_LOCAL_MAC;
        cfg_data <= mac;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Builds a frame of the given kind and offers it byte by byte. Called at
    // a falling edge; returns at the falling edge after the last request.
    task automatic send_frame(input frame_kind_e kind, input fill_e fill, input int len,
                              input logic [15:0] flen);
        int i;
        logic [15:0] et;
        logic [7:0] proto;
        for (i = 0; i < BUF_LEN; i++)
        begin
            case (fill)
                FILL_ZERO: frame_buf[i] = 8'h00;
                FILL_ONES: frame_buf[i] = 8'hff;
                default:   frame_buf[i] = $urandom_range(255);
            endcase
        end
        case (kind)
            FR_ARP_OURS, FR_ARP_OTHER:
            begin
                {frame_buf[12], frame_buf[13]} = ETH_TYPE_ARP;
                {frame_buf[38], frame_buf[39], frame_buf[40], frame_buf[41]} = own_ip;
                if (kind == FR_ARP_OTHER)
                    frame_buf[38 + $urandom_range(3)] ^= 8'h01 << $urandom_range(7);
            end
            FR_ICMP_ECHO:
            begin
                {frame_buf[12], frame_buf[13]} = ETH_TYPE_IPV4;
                frame_buf[23] = IP_PROTO_ICMP;
            end
            FR_IPV4_OTHER:
            begin
                {frame_buf[12], frame_buf[13]} = ETH_TYPE_IPV4;
                proto = $urandom_range(255);
                if (proto == IP_PROTO_ICMP)
                    proto = ~IP_PROTO_ICMP;
                frame_buf[23] = proto;
            end
            FR_ETH_OTHER:
            begin
                // the byte-swapped ARP type is a likely decoding slip
                et = $urandom_range(1) ? ETH_TYPE_ARP_SWAPPED : 16'($urandom_range(65535));
                if (et == ETH_TYPE_ARP || et == ETH_TYPE_IPV4)
                    et = ETH_TYPE_IPV6;
                {frame_buf[12], frame_buf[13]} = et;
            end
            default: ;
        endcase

        for (i = 0; i < len; i++)
        begin
            // random sender gaps; within a frame valid only drops here, never between
            // back-to-back requests
            while ($urandom_range(99) < send_idle)
            begin
                rx_ch.valid <= 1'b0;
                @(negedge clk);
            end
            rx_ch.valid <= 1'b1;
            rx_ch.frame_byte <= frame_buf[i];
            rx_ch.last_byte <= (i == len - 1);
            rx_ch.frame_length <= flen;
            do
                @(posedge clk);
            while (!rx_ch.ready);
            @(negedge clk);
        end
    endtask

    initial
    begin
        int k;
        int round;
        int sent;
        int len;
        int pick;
        frame_kind_e kind;
        fill_e fill;
        logic [15:0] flen;
        logic [31:0] ip;
        logic [47:0] mac;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LOCAL_IP;
        cfg_data = '0;
        rx_ch.valid = 1'b0;
        rx_ch.frame_byte = 8'h00;
        rx_ch.last_byte = 1'b0;
        rx_ch.frame_length = 16'h0000;
        tx_ch.ready = 1'b0;
        send_idle = 7;
        recv_idle = 50;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed plan, light sender gaps and a slow receiver
        for (k = 0; k < N_PLAN; k++)
        begin
            if (PLAN[k].set_cfg)
            begin
                drain_replies();
                load_addresses(PLAN[k].ip, PLAN[k].mac);
            end
            row_status_valid = PLAN[k].typed;
            row_status = PLAN[k].st;
            send_frame(PLAN[k].kind, PLAN[k].fill, PLAN[k].len, PLAN[k].flen);
        end
        row_status_valid = 1'b0;

        // Random rounds: slow receiver, then slow sender, then full speed
        for (round = 0; round < 3; round++)
        begin
            drain_replies();
            case ($urandom_range(3))
                0: ip = '0;
                1: ip = '1;
                default: ip = $urandom;
            endcase
            case ($urandom_range(3))
                0: mac = '0;
                1: mac = '1;
                default: mac = {16'($urandom), 32'($urandom)};
            endcase
            load_addresses(ip, mac);
            send_idle = (round == 0) ? 7 : (round == 1) ? 50 : 0;
            recv_idle = (round == 0) ? 50 : (round == 1) ? 7 : 0;
            sent = 0;
            while (sent < ROUND_BYTES)
            begin
                // mostly well-formed requests; the rest short or noise
                pick = $urandom_range(99);
                kind = (pick < 35) ? FR_ICMP_ECHO :
                       (pick < 60) ? FR_ARP_OURS :
                       (pick < 70) ? FR_ARP_OTHER :
                       (pick < 80) ? FR_IPV4_OTHER :
                       (pick < 85) ? FR_ETH_OTHER : FR_RAW;
                pick = $urandom_range(99);
                fill = (pick < 90) ? FILL_RANDOM : (pick < 95) ? FILL_ZERO : FILL_ONES;
                len = ($urandom_range(99) < 15) ? $urandom_range(HDR_LEN - 1, 1)
                                                : $urandom_range(56, HDR_LEN);
                flen = $urandom_range(1) ? 16'(len) : 16'($urandom_range(65535));
                send_frame(kind, fill, len, flen);
                sent += len;
                // now and then hold off until the block has said everything
                if ($urandom_range(9) == 0)
                    drain_replies();
            end
        end

        drain_replies();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
